// ----- rtl/core/smcp_pkg.sv -----
`timescale 1ns / 1ps

package smcp_pkg;

   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_ZERO   = 8'd48;
   localparam logic [7:0] CH_NINE   = 8'd57;
   localparam logic [7:0] CH_O      = 8'd79;
   localparam logic [7:0] CH_N      = 8'd78;
   localparam logic [7:0] CH_F      = 8'd70;
   localparam logic [7:0] CASE_OFS  = 8'd32;

   localparam logic [6:0] LEVEL_MAX = 7'd100;

   localparam logic [2:0] EV_NONE    = 3'd0;
   localparam logic [2:0] EV_ON      = 3'd1;
   localparam logic [2:0] EV_OFF     = 3'd2;
   localparam logic [2:0] EV_BAD_CMD = 3'd3;
   localparam logic [2:0] EV_BAD_AMT = 3'd4;
   localparam logic [2:0] EV_LEVEL   = 3'd5;

   // 255/100 and 3/100 as reciprocal products, exact for levels up to 100
   localparam logic [20:0] RECIP_255 = 21'd1336965;
   localparam logic [13:0] RECIP_3   = 14'd15729;

   typedef struct packed {
      logic [9:0] duty;
      logic       motor_enable;
      logic [6:0] level_percent;
      logic [2:0] event_res;
   } result_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic is_letter(input logic [7:0] c, input logic [7:0] upper);
      return (c == upper) || (c == (upper + CASE_OFS));
   endfunction

   function automatic logic [9:0] duty_of(input logic [6:0] level);
      logic [27:0] p1;
      logic [20:0] p2;
      logic [8:0]  q1;
      logic [1:0]  q2;
      p1 = {21'd0, level} * {7'd0, RECIP_255};
      p2 = {14'd0, level} * {7'd0, RECIP_3};
      q1 = p1[27:19];
      q2 = p2[20:19];
      return {q1[7:0], 2'b00} + {8'd0, q2};
   endfunction

endpackage

// ----- rtl/core/smcp_in_stage.sv -----
`timescale 1ns / 1ps

module smcp_in_stage
   import smcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   output logic       in_ready,
   input  logic [7:0] in_byte,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   assign in_ready   = !valid_ff || advance;
   assign valid_in   = in_ready ? in_valid : valid_ff;
   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
      end
   end

endmodule

// ----- rtl/core/smcp_parse.sv -----
`timescale 1ns / 1ps

module smcp_parse
   import smcp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] rx_byte,
   output result_type result
);

   logic [7:0] buf_ff [3];
   logic [7:0] buf_in [3];
   logic [1:0] pos_ff;
   logic [1:0] pos_in;
   logic       skip_ff;
   logic       skip_in;
   logic       motor_ff;
   logic       motor_in;
   logic [6:0] level_ff;
   logic [6:0] level_in;
   logic [9:0] duty_ff;
   logic [9:0] duty_in;

   logic [1:0] pos;
   logic       ends;
   logic       skip_mid;
   logic [2:0] ev;
   logic [3:0] d0;
   logic [3:0] d1;
   logic [3:0] d2;
   logic [9:0] value;
   logic       bad_amt;
   logic [6:0] clamped;

   always_comb begin
      pos = (pos_ff > 2'd2) ? 2'd2 : pos_ff;
      for (int i = 0; i < 3; i++) begin
         buf_in[i] = (pos == i[1:0]) ? rx_byte : buf_ff[i];
      end

      d0 = buf_in[0][3:0] - CH_ZERO[3:0];
      d1 = buf_in[1][3:0] - CH_ZERO[3:0];
      d2 = buf_in[2][3:0] - CH_ZERO[3:0];
      if (buf_in[1] == CH_CR) begin
         value   = {6'd0, d0};
         bad_amt = 1'b0;
      end else if (buf_in[2] == CH_CR) begin
         value   = ({6'd0, d0} * 10'd10) + {6'd0, d1};
         bad_amt = !is_digit(buf_in[1]);
      end else begin
         value   = ({6'd0, d0} * 10'd100) + ({6'd0, d1} * 10'd10) + {6'd0, d2};
         bad_amt = !is_digit(buf_in[1]) || !is_digit(buf_in[2]);
      end
      clamped = (value > {3'd0, LEVEL_MAX}) ? LEVEL_MAX : value[6:0];

      ends     = !skip_ff && ((pos == 2'd2) || (rx_byte == CH_CR));
      skip_mid = skip_ff || ends;
      ev       = EV_NONE;
      motor_in = motor_ff;
      level_in = level_ff;
      duty_in  = duty_ff;

      if (ends) begin
         if (is_digit(buf_in[0])) begin
            if (bad_amt) begin
               ev = EV_BAD_AMT;
            end else begin
               ev       = EV_LEVEL;
               level_in = clamped;
               duty_in  = duty_of(clamped);
            end
         end else if (is_letter(buf_in[0], CH_O) && is_letter(buf_in[1], CH_N)
                      && (buf_in[2] == CH_CR)) begin
            ev       = EV_ON;
            motor_in = 1'b1;
         end else if (is_letter(buf_in[0], CH_O) && is_letter(buf_in[1], CH_F)
                      && is_letter(buf_in[2], CH_F)) begin
            ev       = EV_OFF;
            motor_in = 1'b0;
         end else begin
            ev = EV_BAD_CMD;
         end
      end

      if (skip_mid && (rx_byte == CH_LF)) begin
         pos_in  = 2'd0;
         skip_in = 1'b0;
      end else if (!skip_mid) begin
         pos_in  = pos + 2'd1;
         skip_in = 1'b0;
      end else begin
         pos_in  = pos;
         skip_in = 1'b1;
      end

      result.duty          = motor_in ? duty_in : 10'd0;
      result.motor_enable  = motor_in;
      result.level_percent = level_in;
      result.event_res     = ev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            buf_ff[i] <= 8'd0;
         end
         pos_ff   <= 2'd0;
         skip_ff  <= 1'b0;
         motor_ff <= 1'b0;
         level_ff <= 7'd0;
         duty_ff  <= 10'd0;
      end else if (advance) begin
         for (int i = 0; i < 3; i++) begin
            buf_ff[i] <= buf_in[i];
         end
         pos_ff   <= pos_in;
         skip_ff  <= skip_in;
         motor_ff <= motor_in;
         level_ff <= level_in;
         duty_ff  <= duty_in;
      end
   end

endmodule

// ----- rtl/core/serial_motor_command_parser_unit.sv -----
`timescale 1ns / 1ps

// channel   | ports                    | contents
// ----------+--------------------------+-------------------------------------------
// req       | req_tvalid/tready/tdata  | one received serial byte per item
// rsp       | rsp_tvalid/tready/tdata  | duty, motor enable, level, event per item
//
// one item per cycle sustained while rsp is not stalled; rsp valid follows the req accept edge
// through the input register, parse logic and result register
// every input byte gives exactly one result item
// synchronous reset clears the line buffer, motor state, level and duty
// a stalled rsp holds its item; req takes one more item into the input register, then stalls

module serial_motor_command_parser_unit
   import smcp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [9:0] duty, [10] motor_enable,
                                    // [17:11] level_percent, [20:18] event_res, [23:21] zero
);

   logic       held_valid;
   logic [7:0] held_byte;
   logic       advance;
   result_type result;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_data_ff;

   assign advance      = held_valid && (!rsp_valid_ff || rsp_tready);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   smcp_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_byte    (req_tdata),
      .advance    (advance),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   smcp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .rx_byte (held_byte),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_data_ff.event_res, rsp_data_ff.level_percent,
                        rsp_data_ff.motor_enable, rsp_data_ff.duty};

endmodule

// ----- tb/sv/tb_serial_motor_command_parser_unit.sv -----
`timescale 1ns / 1ps

module tb_serial_motor_command_parser_unit;
   import smcp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BYTES = 1050;
   localparam int DRAIN_CYCLES = 20;

   // result item as it sits in rsp_tdata, lowest field last
   typedef struct packed {
      logic [2:0] pad;
      logic [2:0] event_res;
      logic [6:0] level_percent;
      logic       motor_enable;
      logic [9:0] duty;
   } rsp_item_type;

   class motor_rsp_board;
      logic [7:0]   chars [3];
      logic [1:0]   wr_pos;
      logic         skipping;
      logic         motor_on;
      logic [6:0]   level;
      logic [9:0]   duty;
      rsp_item_type pending_rsp [$];
      int           errors;

      function new();
         chars[0] = '0;
         chars[1] = '0;
         chars[2] = '0;
         wr_pos   = '0;
         skipping = 1'b0;
         motor_on = 1'b0;
         level    = '0;
         duty     = '0;
         errors   = 0;
      endfunction

      function bit is_numeral(logic [7:0] c);
         return (c >= CH_ZERO) && (c <= CH_NINE);
      endfunction

      function bit letter_hit(logic [7:0] c, logic [7:0] up);
         return (c == up) || (c == 8'(up + CASE_OFS));
      endfunction

      function logic [2:0] parse_level();
         int v;
         int k;
         v = 0;
         for (k = 0; k < 3 && chars[k] != CH_CR; k++) begin
            if (!is_numeral(chars[k]))
               return EV_BAD_AMT;
            v = v * 10 + int'(chars[k] - CH_ZERO);
         end
         if (v > 100)
            v = 100;
         level = 7'(v);
         duty  = 10'(((v * 255) / 100) * 4 + (v * 3) / 100);
         return EV_LEVEL;
      endfunction

      function logic [2:0] parse_command();
         if (letter_hit(chars[0], CH_O) && letter_hit(chars[1], CH_N) && chars[2] == CH_CR) begin
            motor_on = 1'b1;
            return EV_ON;
         end
         if (letter_hit(chars[0], CH_O) && letter_hit(chars[1], CH_F) &&
             letter_hit(chars[2], CH_F)) begin
            motor_on = 1'b0;
            return EV_OFF;
         end
         return EV_BAD_CMD;
      endfunction

      function void take_byte(logic [7:0] c);
         logic [1:0]   pos;
         rsp_item_type want;
         want = '0;
         want.event_res = EV_NONE;
         pos = (wr_pos > 2'd2) ? 2'd2 : wr_pos;
         chars[pos] = c;
         if (!skipping) begin
            if (pos == 2'd2 || c == CH_CR) begin
               skipping = 1'b1;
               if (is_numeral(chars[0]))
                  want.event_res = parse_level();
               else
                  want.event_res = parse_command();
            end else begin
               pos = pos + 2'd1;
            end
         end
         if (skipping && chars[pos] == CH_LF) begin
            pos = 2'd0;
            skipping = 1'b0;
         end
         wr_pos = pos;
         want.duty          = motor_on ? duty : 10'd0;
         want.motor_enable  = motor_on;
         want.level_percent = level;
         pending_rsp.push_back(want);
      endfunction

      function void check_rsp(logic [23:0] d);
         rsp_item_type got;
         rsp_item_type want;
         got = d;
         if (pending_rsp.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result item %h", d);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.duty !== want.duty || got.motor_enable !== want.motor_enable ||
             got.level_percent !== want.level_percent || got.event_res !== want.event_res ||
             got.pad !== want.pad) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: duty %0d/%0d en %0b/%0b level %0d/%0d event %0d/%0d pad %0d/%0d",
                        want.duty, got.duty, want.motor_enable, got.motor_enable,
                        want.level_percent, got.level_percent, want.event_res,
                        got.event_res, want.pad, got.pad);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;

   motor_rsp_board board = new();
   int             bytes_sent = 0;
   int             cycle_count = 0;
   bit             req_burst = 1'b0;
   bit             rsp_burst = 1'b0;

   serial_motor_command_parser_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic int draw_gap(ref bit burst);
      if ($urandom_range(0, 39) == 0)
         burst = !burst;
      return burst ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_gap(req_burst);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_byte(b);
      bytes_sent++;
   endtask

   task automatic send_bytes(input logic [7:0] q [$]);
      foreach (q[i])
         send_byte(q[i]);
   endtask

   function automatic void push_text(ref logic [7:0] q [$], input string s);
      for (int i = 0; i < s.len(); i++)
         q.push_back(8'(s[i]));
   endfunction

   function automatic logic [7:0] mixed_case(logic [7:0] up);
      return $urandom_range(0, 1) ? 8'(up + CASE_OFS) : up;
   endfunction

   function automatic logic [7:0] non_digit();
      logic [7:0] c;
      c = 8'($urandom);
      while ((c >= CH_ZERO && c <= CH_NINE) || c == CH_CR)
         c = 8'($urandom);
      return c;
   endfunction

   task automatic send_random_line();
      logic [7:0] q [$];
      int kind;
      int n;
      int bad_at;
      int k;
      int pick;
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         q.push_back(mixed_case(CH_O));
         q.push_back(mixed_case(CH_N));
         q.push_back(CH_CR);
      end else if (kind < 30) begin
         q.push_back(mixed_case(CH_O));
         q.push_back(mixed_case(CH_F));
         q.push_back(mixed_case(CH_F));
      end else if (kind < 55) begin
         n = $urandom_range(1, 3);
         for (k = 0; k < n; k++)
            q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
         if (n < 3)
            q.push_back(CH_CR);
      end else if (kind < 60) begin
         push_text(q, "100");
      end else if (kind < 70) begin
         n = $urandom_range(2, 3);
         bad_at = $urandom_range(1, n - 1);
         q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
         for (k = 1; k < n; k++)
            q.push_back(k == bad_at ? non_digit() : 8'(CH_ZERO + $urandom_range(0, 9)));
         if (n < 3)
            q.push_back(CH_CR);
      end else if (kind < 82) begin
         n = $urandom_range(1, 3);
         for (k = 0; k < n; k++) begin
            pick = $urandom_range(0, 4);
            case (pick)
               0: q.push_back(mixed_case(CH_O));
               1: q.push_back(mixed_case(CH_N));
               2: q.push_back(mixed_case(CH_F));
               3: q.push_back(CH_CR);
               default: q.push_back(8'($urandom));
            endcase
         end
         if (n < 3)
            q.push_back(CH_CR);
      end else begin
         n = $urandom_range(1, 4);
         for (k = 0; k < n; k++)
            q.push_back(8'($urandom));
      end
      if ($urandom_range(0, 9) < 8) begin
         if ($urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 2);
            for (k = 0; k < n; k++)
               q.push_back(8'($urandom));
         end
         q.push_back(CH_LF);
      end
      send_bytes(q);
   endtask

   initial begin : rsp_side
      int gap;
      @(negedge reset);
      forever begin
         gap = draw_gap(rsp_burst);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         board.check_rsp(rsp_tdata);
      end
   end

   initial begin : req_side
      logic [7:0] q [$];
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_text(q, "oN");
      q.push_back(CH_CR);
      q.push_back(CH_LF);
      push_text(q, "100");
      q.push_back(CH_LF);
      push_text(q, "0");
      q.push_back(CH_CR);
      q.push_back(CH_LF);
      push_text(q, "999");
      q.push_back(CH_LF);
      q.push_back(CH_CR);
      q.push_back(CH_LF);
      q.push_back(8'hFF);
      q.push_back(8'h00);
      q.push_back(CH_LF);
      push_text(q, "5x");
      q.push_back(CH_CR);
      q.push_back(CH_LF);
      push_text(q, "OfF");
      q.push_back(CH_LF);
      send_bytes(q);

      bytes_sent = 0;
      while (bytes_sent < RANDOM_BYTES)
         send_random_line();

      req_tvalid <= 1'b0;
      while (board.pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0 && board.pending_rsp.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- serial_motor_command_parser_unit.f -----
rtl/core/smcp_pkg.sv
rtl/core/smcp_in_stage.sv
rtl/core/smcp_parse.sv
rtl/core/serial_motor_command_parser_unit.sv
tb/sv/tb_serial_motor_command_parser_unit.sv
